// ----- rtl/shifting_array_list_macros.svh -----
// Assertion macros for the shifting array list checker.
// Uses clk_i and rst_ni from the scope of the including module.
`ifndef SHIFTING_ARRAY_LIST_MACROS_SVH
`define SHIFTING_ARRAY_LIST_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SAL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sal_pkg.sv -----
// Shared types and constants of the shifting array list.
// No dependencies; used by every module of the block.
package sal_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned OpW     = 4;
  localparam int unsigned PosW    = 7;
  localparam int unsigned LenW    = 7;
  localparam int unsigned ErrW    = 2;
  // Upper bound on the cells folded into the result per drain cycle.
  localparam int unsigned LaneMax = 8;

  typedef enum logic [OpW-1:0] {
    OpGet      = 4'd0,
    OpSet      = 4'd1,
    OpInsFirst = 4'd2,
    OpInsAt    = 4'd3,
    OpInsLast  = 4'd4,
    OpDelFirst = 4'd5,
    OpDelAt    = 4'd6,
    OpDelLast  = 4'd7,
    OpSearch   = 4'd8,
    OpStatus   = 4'd9
  } op_e;

  typedef enum logic [ErrW-1:0] {
    ErrOk    = 2'd0,
    ErrRange = 2'd1,
    ErrFull  = 2'd2,
    ErrEmpty = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    CellHold     = 3'd0,
    CellSet      = 3'd1,
    CellIns      = 3'd2,
    CellDel      = 3'd3,
    CellLoadGet  = 3'd4,
    CellLoadSrch = 3'd5,
    CellDrain    = 3'd6
  } cell_mode_e;

  // Broadcast to every cell of the row.
  typedef struct packed {
    cell_mode_e       mode;
    logic [DataW-1:0] value;
  } cell_ctl_t;

  // Partial result carried down the row during a drain.
  typedef struct packed {
    logic             hit;
    logic [DataW-1:0] value;
  } tok_t;

  typedef struct packed {
    logic [DataW-1:0] read_value;
    logic             found;
    logic [LenW-1:0]  list_length;
    logic             is_empty;
    err_e             error_code;
  } res_t;

endpackage

// ----- rtl/shifting_array_list.sv -----
// Top level of the shifting array list: a row of storage cells plus control.
// Depends on sal_pkg, sal_cell and sal_out_queue.
//
//   Channel  Direction  Handshake                Payload
//   -------  ---------  -----------------------  ----------------------------------------
//   in       to block   in_valid_i / in_stall_o  operation_i, position_i, item_value_i
//   out      from block out_valid_o / out_stall_i read_value_o, found_o, list_length_o,
//                                                is_empty_o, error_code_o
//
// Set, insert, delete, status and refused operations finish at the accepting
//   edge: the row shifts or writes and the result enters the queue.
// Get and search start a drain: the cells latch their match tokens at the
//   accepting edge, then the token row drains up to 8 cells a cycle.
// Reset clears the element count, the control state and the result queue;
//   cell contents stay undefined until written.
// A two-entry result queue holds finished transactions; in_stall_o is high
//   during a drain and while the queue is full.
module shifting_array_list #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [sal_pkg::OpW-1:0]        operation_i,
  input  logic [sal_pkg::PosW-1:0]       position_i,
  input  logic signed [sal_pkg::DataW-1:0] item_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [sal_pkg::DataW-1:0] read_value_o,
  output logic                           found_o,
  output logic [sal_pkg::LenW-1:0]       list_length_o,
  output logic                           is_empty_o,
  output logic [sal_pkg::ErrW-1:0]       error_code_o
);

  // Count width holds CAPACITY itself; compares run at the wider of count and position.
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned WideW = (CntW > sal_pkg::PosW) ? CntW : sal_pkg::PosW;
  localparam int unsigned Lanes = (CAPACITY < sal_pkg::LaneMax) ? CAPACITY : sal_pkg::LaneMax;
  localparam int unsigned Steps = (CAPACITY + Lanes - 1) / Lanes;
  localparam int unsigned StepW = $clog2(Steps + 1);
  localparam logic [CntW-1:0]  CapC   = CntW'(CAPACITY);
  localparam logic [StepW-1:0] StepsC = StepW'(Steps);
  localparam logic [StepW-1:0] LastC  = StepW'(1);

  typedef enum logic [1:0] {
    StIdle  = 2'b01,
    StDrain = 2'b10
  } state_e;

  state_e                     state_q, state_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [StepW-1:0]           step_q, step_d;
  sal_pkg::tok_t              acc_q, acc_d, lane_or;
  sal_pkg::cell_ctl_t         ctl;
  logic [CntW-1:0]            at;
  logic                       accept, push, q_full, q_valid;
  sal_pkg::res_t              res, q_data;
  sal_pkg::err_e              err;
  logic [WideW-1:0]           len_w;

  logic [sal_pkg::DataW-1:0]  data_w [CAPACITY];
  sal_pkg::tok_t              tok_w  [CAPACITY];

  // ---------------------------------------------------------------------------
  // Cell row: cell k holds list element k and talks only to its neighbors
  // (k-1 and k+1 for shifts, k+Lanes for the token drain).
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [sal_pkg::DataW-1:0] prev_data, next_data;
    sal_pkg::tok_t             drain_tok;

    if (k == 0) begin : g_first
      assign prev_data = '0;
    end else begin : g_mid_prev
      assign prev_data = data_w[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign next_data = '0;
    end else begin : g_mid_next
      assign next_data = data_w[k+1];
    end

    // Cells near the top pull zeros into the drain
    if (k + Lanes < CAPACITY) begin : g_drain
      assign drain_tok = tok_w[k+Lanes];
    end else begin : g_drain_end
      assign drain_tok = '0;
    end

    sal_cell #(
      .CntW  (CntW),
      .Index (k)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .at_i        (at),
      .prev_data_i (prev_data),
      .next_data_i (next_data),
      .drain_tok_i (drain_tok),
      .data_o      (data_w[k]),
      .tok_o       (tok_w[k])
    );
  end

  // Fold the lowest Lanes tokens into the running result.
  always_comb begin
    lane_or = acc_q;
    for (int i = 0; i < Lanes; i++) begin
      lane_or.hit   = lane_or.hit | tok_w[i].hit;
      lane_or.value = lane_or.value | tok_w[i].value;
    end
  end

  // ---------------------------------------------------------------------------
  // Operation decode and control
  // ---------------------------------------------------------------------------
  assign in_stall_o = (state_q != StIdle) | q_full;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    logic [WideW-1:0] pos_w, cnt_w, at_w, tgt;
    logic             drain_go;

    pos_w     = WideW'(position_i);
    cnt_w     = WideW'(cnt_q);
    at_w      = '0;
    tgt       = '0;
    err       = sal_pkg::ErrOk;
    drain_go  = 1'b0;
    ctl.mode  = sal_pkg::CellHold;
    ctl.value = item_value_i;
    cnt_d     = cnt_q;
    state_d   = state_q;
    step_d    = step_q;
    acc_d     = acc_q;
    push      = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (sal_pkg::op_e'(operation_i))
            sal_pkg::OpGet: begin
              if (pos_w < cnt_w) begin
                ctl.mode = sal_pkg::CellLoadGet;
                at_w     = pos_w;
                drain_go = 1'b1;
              end else begin
                err = sal_pkg::ErrRange;
              end
            end
            sal_pkg::OpSet: begin
              if (pos_w < cnt_w) begin
                ctl.mode = sal_pkg::CellSet;
                at_w     = pos_w;
              end else begin
                err = sal_pkg::ErrRange;
              end
            end
            sal_pkg::OpInsFirst, sal_pkg::OpInsAt, sal_pkg::OpInsLast: begin
              // Full check first, then the index check
              priority if (operation_i == sal_pkg::OpInsFirst) tgt = '0;
              else if (operation_i == sal_pkg::OpInsLast)      tgt = cnt_w;
              else                                             tgt = pos_w;
              if (cnt_q == CapC) begin
                err = sal_pkg::ErrFull;
              end else if (tgt > cnt_w) begin
                err = sal_pkg::ErrRange;
              end else begin
                ctl.mode = sal_pkg::CellIns;
                at_w     = tgt;
                cnt_d    = cnt_q + CntW'(1);
              end
            end
            sal_pkg::OpDelFirst, sal_pkg::OpDelAt, sal_pkg::OpDelLast: begin
              // Empty check first, then the index check
              priority if (operation_i == sal_pkg::OpDelFirst) tgt = '0;
              else if (operation_i == sal_pkg::OpDelLast)      tgt = cnt_w - WideW'(1);
              else                                             tgt = pos_w;
              if (cnt_q == '0) begin
                err = sal_pkg::ErrEmpty;
              end else if (tgt >= cnt_w) begin
                err = sal_pkg::ErrRange;
              end else begin
                ctl.mode = sal_pkg::CellDel;
                at_w     = tgt;
                cnt_d    = cnt_q - CntW'(1);
              end
            end
            sal_pkg::OpSearch: begin
              // Hand the count to the cells as the fill limit
              ctl.mode = sal_pkg::CellLoadSrch;
              at_w     = cnt_w;
              drain_go = 1'b1;
            end
            default: begin
              // Status and unused codes: report only
            end
          endcase

          if (drain_go) begin
            state_d = StDrain;
            step_d  = StepsC;
            acc_d   = '0;
          end else begin
            push = 1'b1;
          end
        end
      end
      StDrain: begin
        // Advance the token row and accumulate; list and count hold
        ctl.mode = sal_pkg::CellDrain;
        acc_d    = lane_or;
        step_d   = step_q - StepW'(1);
        if (step_q == LastC) begin
          push    = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    at = at_w[CntW-1:0];
  end

  // Result assembly: a drained get or search reports its tokens, all else reads zero.
  assign len_w            = WideW'(cnt_d);
  assign res.read_value   = (state_q == StDrain) ? lane_or.value : '0;
  assign res.found        = (state_q == StDrain) ? lane_or.hit : 1'b0;
  assign res.list_length  = len_w[sal_pkg::LenW-1:0];
  assign res.is_empty     = (cnt_d == '0);
  assign res.error_code   = err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
    end
  end

  // Accumulator is payload: cleared whenever a drain starts
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // ---------------------------------------------------------------------------
  // Result queue: finished transactions wait here for the output channel
  // ---------------------------------------------------------------------------
  sal_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res),
    .pop_i       (q_valid & ~out_stall_i),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .full_o      (q_full)
  );

  assign out_valid_o   = q_valid;
  assign read_value_o  = q_data.read_value;
  assign found_o       = q_data.found;
  assign list_length_o = q_data.list_length;
  assign is_empty_o    = q_data.is_empty;
  assign error_code_o  = q_data.error_code;

endmodule

// ----- rtl/sal_cell.sv -----
// One storage cell of the shifting array list row.
// Depends on sal_pkg for the control and token types.
module sal_cell #(
  parameter int unsigned CntW  = 7,
  parameter int unsigned Index = 0
) (
  input  logic                     clk_i,
  input  sal_pkg::cell_ctl_t       ctl_i,
  input  logic [CntW-1:0]          at_i,
  input  logic [sal_pkg::DataW-1:0] prev_data_i,
  input  logic [sal_pkg::DataW-1:0] next_data_i,
  input  sal_pkg::tok_t            drain_tok_i,
  output logic [sal_pkg::DataW-1:0] data_o,
  output sal_pkg::tok_t            tok_o
);

  localparam logic [CntW-1:0] Idx = CntW'(Index);

  logic [sal_pkg::DataW-1:0] data_q, data_d;
  sal_pkg::tok_t             tok_q, tok_d;
  logic                      is_at, above, below;

  assign is_at = (Idx == at_i);
  assign above = (Idx > at_i);
  assign below = (Idx < at_i);

  always_comb begin
    data_d = data_q;
    tok_d  = tok_q;
    unique case (ctl_i.mode)
      sal_pkg::CellSet: begin
        if (is_at) data_d = ctl_i.value;
      end
      sal_pkg::CellIns: begin
        if (is_at) begin
          data_d = ctl_i.value;
        end else if (above) begin
          data_d = prev_data_i;
        end
      end
      sal_pkg::CellDel: begin
        if (is_at || above) data_d = next_data_i;
      end
      sal_pkg::CellLoadGet: begin
        tok_d.hit   = 1'b0;
        tok_d.value = is_at ? data_q : '0;
      end
      sal_pkg::CellLoadSrch: begin
        // at_i carries the element count here: only filled cells may hit
        tok_d.hit   = below && (data_q == ctl_i.value);
        tok_d.value = '0;
      end
      sal_pkg::CellDrain: begin
        tok_d = drain_tok_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    tok_q  <= tok_d;
  end

  assign data_o = data_q;
  assign tok_o  = tok_q;

endmodule

// ----- rtl/sal_out_queue.sv -----
// Two-entry result queue between the list core and the output channel.
// Depends on sal_pkg for the result type.
module sal_out_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sal_pkg::res_t push_data_i,
  input  logic          pop_i,
  output logic          valid_o,
  output sal_pkg::res_t data_o,
  output logic          full_o
);

  localparam logic [1:0] Depth = 2'd2;

  sal_pkg::res_t slot_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == Depth);
  assign data_o  = slot_q[rd_q];

endmodule

// ----- rtl/sal_checker.sv -----
// Port-level checker for the shifting array list, bound to the top level.
// Depends on sal_pkg and shifting_array_list_macros.svh.
`include "shifting_array_list_macros.svh"

module sal_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic signed [sal_pkg::DataW-1:0] read_value_o,
  input logic                            found_o,
  input logic [sal_pkg::LenW-1:0]        list_length_o,
  input logic                            is_empty_o,
  input logic [sal_pkg::ErrW-1:0]        error_code_o
);

  `SAL_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(read_value_o) && $stable(found_o) && $stable(list_length_o) && $stable(is_empty_o) && $stable(error_code_o), "stalled result transaction changed")

  `SAL_ASSERT_NOW(a_hit_clean, out_valid_o && found_o, error_code_o == sal_pkg::ErrOk && read_value_o == '0 && !is_empty_o, "search hit with error, read data or empty list")

  `SAL_ASSERT_NOW(a_empty_err, out_valid_o && error_code_o == sal_pkg::ErrEmpty, is_empty_o && list_length_o == '0, "empty error on a non-empty list")

  `SAL_ASSERT_NOW(a_full_err, out_valid_o && error_code_o == sal_pkg::ErrFull, !is_empty_o && !found_o, "full error on an empty list")

endmodule

bind shifting_array_list sal_checker u_sal_checker (.*);
